@@ src/sall_pkg.sv @@
// ============================================================================
// sall_pkg
// Shared types and constants for the sorted linked list core.
// ============================================================================
package sall_pkg;

    // Store geometry
    localparam int SLOTS  = 1024;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int PTR_W  = $clog2(SLOTS + 1);
    localparam int KEY_W  = 32;
    localparam int SLOT_W = 10;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [PTR_W-1:0] t_ptr;

    // Null link: one past the last slot
    localparam t_ptr NIL = PTR_W'(SLOTS);

    // Opcodes
    localparam logic [1:0] OP_SEARCH = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_SWAP   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NO_SUCC = 2'd3;

    typedef struct packed {
        logic [1:0]              opcode;
        logic signed [KEY_W-1:0] key;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
    } t_out;

    // Write request into the link store
    typedef struct packed {
        logic en;
        t_idx addr;
        t_ptr data;
    } t_link_wr;

endpackage

@@ src/sall_ram.sv @@
// ============================================================================
// sall_ram
// Single-port-write, single-port-read synchronous RAM with a registered read port.
// ============================================================================
module sall_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/sall_lnk.sv @@
// ============================================================================
// sall_lnk
// Link store: successor memory plus a fill count that stands in for the
// reset free chain (every slot at or above the count links to slot + 1).
// ============================================================================
module sall_lnk (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_re,
    input  sall_pkg::t_idx    i_raddr,
    output sall_pkg::t_ptr    o_rdata,
    input  sall_pkg::t_link_wr i_wr
);
    import sall_pkg::*;

    t_ptr ram_rdata;
    t_ptr r_fill;
    t_ptr n_fill;
    logic r_fresh;
    t_idx r_raddr;

    sall_ram #(
        .DEPTH (SLOTS),
        .WIDTH (PTR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_re    (i_re),
        .i_raddr (i_raddr),
        .o_rdata (ram_rdata)
    );

    // Advance the fill count when the first untouched slot gets written
    always_comb begin
        n_fill = r_fill;
        if (i_wr.en && (PTR_W'(i_wr.addr) == r_fill)) begin
            n_fill = r_fill + PTR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // Remember whether the read hit an untouched slot
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_fresh <= (PTR_W'(i_raddr) >= r_fill);
            r_raddr <= i_raddr;
        end
    end

    // Untouched slots read as the reset free chain
    assign o_rdata = r_fresh ? (PTR_W'(r_raddr) + PTR_W'(1)) : ram_rdata;

endmodule

@@ src/sorted_array_linked_list_core.sv @@
// ============================================================================
// sorted_array_linked_list_core
// Ascending linked list of signed keys held in slot memories, with a free
// chain; search, insert, delete and swap-with-successor, one result per item.
// ============================================================================
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------
//  input   | in        | i_in_valid / o_in_ready    | i_in_data  (t_in)
//  output  | out       | o_out_valid / i_out_ready  | o_out_data (t_out)
//
//  An item's walk visits up to SLOTS list nodes, reading one key and one
//  link per cycle from the slot memories, and relinking does one link
//  write per cycle.
//  No clearing pass runs at reset: a fill count marks untouched link
//  entries.
//  The result sits in an output register; the next item is taken once the
//  result has moved into it, while that register may still be stalled.
//
module sorted_array_linked_list_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sall_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sall_pkg::t_out o_out_data
);
    import sall_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_RD2  = 3'd3;
    localparam logic [2:0] S_WR1  = 3'd4;
    localparam logic [2:0] S_WR2  = 3'd5;
    localparam logic [2:0] S_RESP = 3'd6;

    logic [2:0]              r_state, n_state;
    logic [1:0]              r_op, n_op;
    logic signed [KEY_W-1:0] r_key, n_key;
    t_ptr                    r_cur, n_cur;
    t_ptr                    r_prev, n_prev;
    t_ptr                    r_cnt, n_cnt;
    logic                    r_found, n_found;
    t_ptr                    r_hl, n_hl;
    t_ptr                    r_list_head, n_list_head;
    t_ptr                    r_free_head, n_free_head;
    t_ptr                    r_wa, n_wa;
    t_ptr                    r_wd, n_wd;
    logic                    r_w2, n_w2;
    t_ptr                    r_wa2, n_wa2;
    t_ptr                    r_wd2, n_wd2;
    t_out                    r_res, n_res;
    logic                    r_out_valid, n_out_valid;
    t_out                    r_out, n_out;

    logic                    rd_en;
    t_idx                    rd_addr;
    logic [KEY_W-1:0]        key_rdata;
    logic                    key_we;
    t_idx                    key_waddr;
    logic [KEY_W-1:0]        key_wdata;
    t_ptr                    lnk_rdata;
    t_link_wr                lnk_wr;
    logic                    in_xfer;
    logic                    out_free;

    // Key memory
    sall_ram #(
        .DEPTH (SLOTS),
        .WIDTH (KEY_W)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (key_rdata)
    );

    // Link memory with reset free chain
    sall_lnk u_lnk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (lnk_rdata),
        .i_wr    (lnk_wr)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // Sequencer: walk, then relink one write per cycle
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_cnt       = r_cnt;
        n_found     = r_found;
        n_hl        = r_hl;
        n_list_head = r_list_head;
        n_free_head = r_free_head;
        n_wa        = r_wa;
        n_wd        = r_wd;
        n_w2        = r_w2;
        n_wa2       = r_wa2;
        n_wd2       = r_wd2;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        rd_en       = 1'b0;
        rd_addr     = r_cur[IDX_W-1:0];
        key_we      = 1'b0;
        key_waddr   = r_free_head[IDX_W-1:0];
        key_wdata   = r_key;
        lnk_wr.en   = 1'b0;
        lnk_wr.addr = r_wa[IDX_W-1:0];
        lnk_wr.data = r_wd;

        case (r_state)
            S_IDLE: begin
                // Take an item and start reading at the list head
                if (in_xfer) begin
                    n_op    = i_in_data.opcode;
                    n_key   = i_in_data.key;
                    n_cur   = r_list_head;
                    n_prev  = NIL;
                    n_cnt   = '0;
                    n_found = 1'b0;
                    rd_en   = (r_list_head != NIL);
                    rd_addr = r_list_head[IDX_W-1:0];
                    n_state = S_WALK;
                end
            end

            S_WALK: begin
                // One node per cycle; the next address comes from the link read
                if ((r_cur == NIL) || (r_cnt == NIL)) begin
                    n_state = S_EXEC;
                end else if ($signed(key_rdata) > r_key) begin
                    n_state = S_EXEC;
                end else if ($signed(key_rdata) == r_key) begin
                    n_found = 1'b1;
                    n_hl    = lnk_rdata;
                    n_state = S_EXEC;
                end else begin
                    n_prev  = r_cur;
                    n_cur   = lnk_rdata;
                    n_cnt   = r_cnt + PTR_W'(1);
                    rd_en   = (lnk_rdata != NIL);
                    rd_addr = lnk_rdata[IDX_W-1:0];
                end
            end

            S_EXEC: begin
                n_state = S_RESP;
                case (r_op)
                    OP_SEARCH: begin
                        if (r_found) begin
                            n_res = '{status: ST_DONE, slot: SLOT_W'(r_cur)};
                        end else begin
                            n_res = '{status: ST_MISSING, slot: '0};
                        end
                    end
                    OP_INSERT: begin
                        // Fetch the successor of the free head
                        if (r_free_head == NIL) begin
                            n_res = '{status: ST_FULL, slot: '0};
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_free_head[IDX_W-1:0];
                            n_state = S_RD2;
                        end
                    end
                    OP_DELETE: begin
                        // Unlink the match, then push it onto the free chain
                        if (!r_found) begin
                            n_res = '{status: ST_MISSING, slot: '0};
                        end else begin
                            if (r_prev != NIL) begin
                                lnk_wr.en   = 1'b1;
                                lnk_wr.addr = r_prev[IDX_W-1:0];
                                lnk_wr.data = r_hl;
                            end else begin
                                n_list_head = r_hl;
                            end
                            n_wa        = r_cur;
                            n_wd        = r_free_head;
                            n_w2        = 1'b0;
                            n_free_head = r_cur;
                            n_res       = '{status: ST_DONE, slot: SLOT_W'(r_cur)};
                            n_state     = S_WR1;
                        end
                    end
                    default: begin
                        // Swap: fetch the link after the successor
                        if (!r_found) begin
                            n_res = '{status: ST_MISSING, slot: '0};
                        end else if (r_hl == NIL) begin
                            n_res = '{status: ST_NO_SUCC, slot: '0};
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_hl[IDX_W-1:0];
                            n_state = S_RD2;
                        end
                    end
                endcase
            end

            S_RD2: begin
                if (r_op == OP_INSERT) begin
                    // Claim the free head and link it ahead of the current node
                    n_free_head = lnk_rdata;
                    key_we      = 1'b1;
                    key_waddr   = r_free_head[IDX_W-1:0];
                    key_wdata   = r_key;
                    lnk_wr.en   = 1'b1;
                    lnk_wr.addr = r_free_head[IDX_W-1:0];
                    lnk_wr.data = r_cur;
                    n_res       = '{status: ST_DONE, slot: SLOT_W'(r_free_head)};
                    if (r_prev != NIL) begin
                        n_wa    = r_prev;
                        n_wd    = r_free_head;
                        n_w2    = 1'b0;
                        n_state = S_WR1;
                    end else begin
                        n_list_head = r_free_head;
                        n_state     = S_RESP;
                    end
                end else begin
                    // Swap: successor points back to the match
                    lnk_wr.en   = 1'b1;
                    lnk_wr.addr = r_hl[IDX_W-1:0];
                    lnk_wr.data = r_cur;
                    n_wa        = r_cur;
                    n_wd        = lnk_rdata;
                    n_wa2       = r_prev;
                    n_wd2       = r_hl;
                    n_w2        = (r_prev != NIL);
                    if (r_prev == NIL) begin
                        n_list_head = r_hl;
                    end
                    n_res   = '{status: ST_DONE, slot: SLOT_W'(r_cur)};
                    n_state = S_WR1;
                end
            end

            S_WR1: begin
                lnk_wr.en   = 1'b1;
                lnk_wr.addr = r_wa[IDX_W-1:0];
                lnk_wr.data = r_wd;
                n_state     = r_w2 ? S_WR2 : S_RESP;
            end

            S_WR2: begin
                lnk_wr.en   = 1'b1;
                lnk_wr.addr = r_wa2[IDX_W-1:0];
                lnk_wr.data = r_wd2;
                n_state     = S_RESP;
            end

            S_RESP: begin
                // Hold until the output register frees up
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_list_head <= NIL;
            r_free_head <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_list_head <= n_list_head;
            r_free_head <= n_free_head;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_key   <= n_key;
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_cnt   <= n_cnt;
        r_found <= n_found;
        r_hl    <= n_hl;
        r_wa    <= n_wa;
        r_wd    <= n_wd;
        r_w2    <= n_w2;
        r_wa2   <= n_wa2;
        r_wd2   <= n_wd2;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ src/sall_checker.sv @@
// ============================================================================
// sall_checker
// Port-level checks for the sorted linked list core, bound to the top level.
// ============================================================================
module sall_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input sall_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input sall_pkg::t_out o_out_data
);
    import sall_pkg::*;

    // A failed operation reports slot zero
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_DONE)) |-> (o_out_data.slot == '0))
        else $error("result with failing status carries a nonzero slot");

    // One item at a time: ready drops right after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready stayed high after a transfer");

    // A new result shows up together with readiness for the next item
    a_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result appeared while input was not ready");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or dropped");

endmodule

bind sorted_array_linked_list_core sall_checker u_sall_checker (.*);
